// ----- sv/ilie_pkg.sv -----
// Package for the indexed list: payload types, operation and status codes, defaults.
`timescale 1ns / 1ps
`default_nettype none

package ilie_pkg;

  // Fixed field widths of the item ports.
  localparam int WORD_W    = 32;
  localparam int POS_W     = 5;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 5;

  // Default list geometry.
  localparam int DEF_DEPTH = 16;
  localparam int DEF_WIDTH = 32;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_DROP   = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;
  localparam logic [OP_W-1:0] OP_FRONT  = 3'd6;
  localparam logic [OP_W-1:0] OP_BACK   = 3'd7;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Request item.
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [POS_W-1:0]  position;
    logic [WORD_W-1:0] word_in;
  } req_t;

  // Response item.
  typedef struct packed {
    logic [WORD_W-1:0]    word_out;
    logic [STATUS_W-1:0]  status;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 is_empty;
  } rsp_t;

  // Shift command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic era;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- sv/ilie_cell.sv -----
// One storage cell of the list: holds a word and trades it with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module ilie_cell #(
  parameter int WIDTH = ilie_pkg::DEF_WIDTH,
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  logic                  clk,
  input  ilie_pkg::cell_cmd_t   cmd,
  input  logic [IDX_W-1:0]      pos,
  input  logic [WIDTH-1:0]      word_new,
  input  logic [WIDTH-1:0]      left,
  input  logic [WIDTH-1:0]      right,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_idx,
  output logic [WIDTH-1:0]      word,
  output logic [WIDTH-1:0]      rd_word
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [WIDTH-1:0] word_next;

  // Insert: the target cell takes the new word, cells above it take the lower
  // neighbor. Erase: the target cell and all above take the upper neighbor.
  always_comb begin
    word_next = word;
    if (cmd.ins) begin
      if (pos == MY_IDX) begin
        word_next = word_new;
      end else if (pos < MY_IDX) begin
        word_next = left;
      end
    end else if (cmd.era) begin
      if (pos <= MY_IDX) begin
        word_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

  // The selected cell drives its word onto the shared read bus; others give zero.
  assign rd_word = (rd_en && (rd_idx == MY_IDX)) ? word : '0;

endmodule

`default_nettype wire

// ----- sv/ilie_ctrl.sv -----
// Control for the indexed list: decodes an item, checks bounds, keeps the count.
`timescale 1ns / 1ps
`default_nettype none

module ilie_ctrl #(
  parameter int DEPTH = ilie_pkg::DEF_DEPTH,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  ilie_pkg::req_t                    req,
  output ilie_pkg::cell_cmd_t               cmd,
  output logic [IDX_W-1:0]                  pos,
  output logic                              rd_en,
  output logic [IDX_W-1:0]                  rd_idx,
  output logic [ilie_pkg::STATUS_W-1:0]     status,
  output logic [CNT_W-1:0]                  count,
  output logic [CNT_W-1:0]                  count_next
);

  localparam int CMP_W = (CNT_W > ilie_pkg::POS_W) ? CNT_W : ilie_pkg::POS_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             empty;
  logic             full;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] cnt_dec;

  assign pos_x   = CMP_W'(req.position);
  assign cnt_x   = CMP_W'(count);
  assign empty   = (count == '0);
  assign full    = (count == FULL_CNT);
  assign cnt_inc = count + CNT_W'(1);
  assign cnt_dec = count - CNT_W'(1);

  // Decode the operation into a cell command, a read select, a status and
  // the count after the item.
  always_comb begin
    cmd        = '0;
    pos        = pos_x[IDX_W-1:0];
    rd_en      = 1'b0;
    rd_idx     = pos_x[IDX_W-1:0];
    status     = ilie_pkg::ST_OK;
    count_next = count;
    case (req.operation)
      ilie_pkg::OP_APPEND: begin
        pos = count[IDX_W-1:0];
        if (full) begin
          status = ilie_pkg::ST_FULL;
        end else begin
          cmd.ins    = 1'b1;
          count_next = cnt_inc;
        end
      end
      ilie_pkg::OP_DROP: begin
        if (empty) begin
          status = ilie_pkg::ST_RANGE;
        end else begin
          count_next = cnt_dec;
        end
      end
      ilie_pkg::OP_INSERT: begin
        if (pos_x > cnt_x) begin
          status = ilie_pkg::ST_RANGE;
        end else if (full) begin
          status = ilie_pkg::ST_FULL;
        end else begin
          cmd.ins    = 1'b1;
          count_next = cnt_inc;
        end
      end
      ilie_pkg::OP_ERASE: begin
        if (pos_x >= cnt_x) begin
          status = ilie_pkg::ST_RANGE;
        end else begin
          cmd.era    = 1'b1;
          count_next = cnt_dec;
        end
      end
      ilie_pkg::OP_READ: begin
        if (pos_x >= cnt_x) begin
          status = ilie_pkg::ST_RANGE;
        end else begin
          rd_en = 1'b1;
        end
      end
      ilie_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      ilie_pkg::OP_FRONT: begin
        rd_idx = '0;
        if (empty) begin
          status = ilie_pkg::ST_RANGE;
        end else begin
          rd_en = 1'b1;
        end
      end
      ilie_pkg::OP_BACK: begin
        rd_idx = cnt_dec[IDX_W-1:0];
        if (empty) begin
          status = ilie_pkg::ST_RANGE;
        end else begin
          rd_en = 1'b1;
        end
      end
      default: begin
        status = ilie_pkg::ST_OK;
      end
    endcase
    // Nothing moves unless an item is actually taken.
    if (!fire) begin
      cmd   = '0;
      rd_en = 1'b0;
    end
  end

  // Entry count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/indexed_list_insert_erase_top.sv -----
// Top level of the indexed list: control, row of storage cells, response register.
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to DEPTH words with append, drop, insert, erase, read,
// front, back and clear.
//
// Request channel: an item on req is taken at a rising edge where start is
// high and busy is low. Every operation finishes in the cycle it is taken,
// so busy stays low and a new item may be started every cycle.
// Response channel: in the cycle after an item is taken, done is high for one
// cycle and rsp carries the word read, the status, the entry count after the
// operation and the empty flag. The receiver cannot stall; it must take the
// item in that cycle.
// Throughput is one item per cycle. Insert and erase move every affected word
// one place in the row of cells in the cycle the item is taken.
// Reset clears the entry count and the response strobe; stored words are not
// cleared and are only read once written.
module indexed_list_insert_erase_top #(
  parameter int DEPTH = ilie_pkg::DEF_DEPTH,
  parameter int WIDTH = ilie_pkg::DEF_WIDTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  ilie_pkg::req_t req,
  output logic           done,
  output ilie_pkg::rsp_t rsp
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                          fire;
  ilie_pkg::cell_cmd_t           cmd;
  logic [IDX_W-1:0]              pos;
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_idx;
  logic [ilie_pkg::STATUS_W-1:0] status;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_next;
  logic [WIDTH-1:0]              word_new;
  logic [WIDTH-1:0]              cell_word [DEPTH];
  logic [WIDTH-1:0]              cell_rd   [DEPTH];
  logic [WIDTH-1:0]              rd_word;
  ilie_pkg::rsp_t                rsp_next;

  // Every item completes in its own cycle.
  assign busy     = 1'b0;
  assign fire     = start && !busy;
  assign word_new = WIDTH'(req.word_in);

  ilie_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .req        (req),
    .cmd        (cmd),
    .pos        (pos),
    .rd_en      (rd_en),
    .rd_idx     (rd_idx),
    .status     (status),
    .count      (count),
    .count_next (count_next)
  );

  // Row of cells; each sees the words of its lower and upper neighbor.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] left;
    logic [WIDTH-1:0] right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_word[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_word[i+1];
    end

    ilie_cell #(
      .WIDTH (WIDTH),
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .pos      (pos),
      .word_new (word_new),
      .left     (left),
      .right    (right),
      .rd_en    (rd_en),
      .rd_idx   (rd_idx),
      .word     (cell_word[i]),
      .rd_word  (cell_rd[i])
    );
  end

  // Read bus: at most one cell drives a nonzero word.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  // Response item assembly.
  always_comb begin
    rsp_next.word_out    = ilie_pkg::WORD_W'(rd_word);
    rsp_next.status      = status;
    rsp_next.entry_count = ilie_pkg::CNT_OUT_W'(count_next);
    rsp_next.is_empty    = (count_next == '0);
  end

  // Response register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  // Every taken item yields exactly one response in the next cycle.
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    fire |=> done)
    else $error("response strobe missing after a taken item");

  a_no_stray_done: assert property (@(posedge clk) disable iff (rst)
    !fire |=> !done)
    else $error("response strobe without a taken item");

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // A full report only comes from a list that is still full.
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == ilie_pkg::ST_FULL)) |-> (count == CNT_W'(DEPTH)))
    else $error("full status on a list that is not full");

  // A failed operation never returns data.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status != ilie_pkg::ST_OK)) |-> (rsp.word_out == '0))
    else $error("nonzero word on a failed operation");
`endif

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the indexed list block with its own list predictor.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

  localparam int LIST_DEPTH     = ilie_pkg::DEF_DEPTH;
  localparam int MAX_GAP        = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 475;

  logic           clk;
  logic           rst;
  logic           start;
  logic           busy;
  ilie_pkg::req_t req;
  logic           done;
  ilie_pkg::rsp_t rsp;

  // Predictor state: the list contents and the entry count.
  logic [ilie_pkg::WORD_W-1:0] list_words [LIST_DEPTH];
  int                          list_len;

  ilie_pkg::rsp_t expected_rsp_q [$];
  int             accepted_items;
  int             checked_results;
  int             fail_count;
  int             range_results;
  int             full_results;
  int             full_reached;
  int             sender_idle_pct;
  int             idle_cycles;

  indexed_list_insert_erase_top u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  // Free-running clock, 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one operation to the predicted list and returns the expected result.
  function automatic ilie_pkg::rsp_t predict_list_op(ilie_pkg::req_t item);
    ilie_pkg::rsp_t res;
    int             pos;
    res = '0;
    pos = item.position;
    case (item.operation)
      ilie_pkg::OP_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          res.status = ilie_pkg::ST_FULL;
        end else begin
          list_words[list_len] = item.word_in;
          list_len++;
        end
      end
      ilie_pkg::OP_DROP: begin
        if (list_len == 0) res.status = ilie_pkg::ST_RANGE;
        else list_len--;
      end
      ilie_pkg::OP_INSERT: begin
        // The position check wins over the full check.
        if (pos > list_len) begin
          res.status = ilie_pkg::ST_RANGE;
        end else if (list_len >= LIST_DEPTH) begin
          res.status = ilie_pkg::ST_FULL;
        end else begin
          for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = item.word_in;
          list_len++;
        end
      end
      ilie_pkg::OP_ERASE: begin
        if (pos >= list_len) begin
          res.status = ilie_pkg::ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      ilie_pkg::OP_READ: begin
        if (pos >= list_len) res.status = ilie_pkg::ST_RANGE;
        else res.word_out = list_words[pos];
      end
      ilie_pkg::OP_CLEAR: begin
        list_len = 0;
      end
      ilie_pkg::OP_FRONT: begin
        if (list_len == 0) res.status = ilie_pkg::ST_RANGE;
        else res.word_out = list_words[0];
      end
      ilie_pkg::OP_BACK: begin
        if (list_len == 0) res.status = ilie_pkg::ST_RANGE;
        else res.word_out = list_words[list_len-1];
      end
      default: ;
    endcase
    res.entry_count = ilie_pkg::CNT_OUT_W'(list_len);
    res.is_empty    = (list_len == 0);
    if (list_len == LIST_DEPTH) full_reached++;
    return res;
  endfunction

  // Checks each result against the oldest expectation, then predicts any new item.
  always @(posedge clk) begin
    ilie_pkg::rsp_t exp_rsp;
    ilie_pkg::rsp_t pred_rsp;
    if (!rst) begin
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          $error("Result arrived with no item outstanding");
          fail_count++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          checked_results++;
          if (exp_rsp.status == ilie_pkg::ST_RANGE) range_results++;
          if (exp_rsp.status == ilie_pkg::ST_FULL) full_results++;
          if (rsp.word_out !== exp_rsp.word_out) begin
            $error("word_out: expected %h, got %h", exp_rsp.word_out, rsp.word_out);
            fail_count++;
          end
          if (rsp.status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
            fail_count++;
          end
          if (rsp.entry_count !== exp_rsp.entry_count) begin
            $error("entry_count: expected %0d, got %0d", exp_rsp.entry_count,
                   rsp.entry_count);
            fail_count++;
          end
          if (rsp.is_empty !== exp_rsp.is_empty) begin
            $error("is_empty: expected %0b, got %0b", exp_rsp.is_empty, rsp.is_empty);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        pred_rsp       = predict_list_op(req);
        expected_rsp_q = {expected_rsp_q, pred_rsp};
        accepted_items++;
      end
    end
  end

  // Watchdog: ends the run when neither an item nor a result moves for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Sends one item, with a random idle gap first, and returns once it is taken.
  task automatic send_item(input logic [ilie_pkg::OP_W-1:0]   op,
                           input logic [ilie_pkg::POS_W-1:0]  pos,
                           input logic [ilie_pkg::WORD_W-1:0] word);
    int gap;
    int target;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
      gap++;
    end
    target = accepted_items + 1;
    start <= 1'b1;
    req   <= '{operation: op, position: pos, word_in: word};
    do @(negedge clk); while (accepted_items < target);
  endtask

  // Reads, drops and erases on an empty list, and a bad insert position.
  task automatic test_empty_list();
    send_item(ilie_pkg::OP_FRONT, 5'd0, 32'h0);
    send_item(ilie_pkg::OP_BACK, 5'd0, 32'h0);
    send_item(ilie_pkg::OP_DROP, 5'd0, 32'h0);
    send_item(ilie_pkg::OP_READ, 5'd0, 32'h0);
    send_item(ilie_pkg::OP_ERASE, 5'd0, 32'h0);
    send_item(ilie_pkg::OP_INSERT, 5'd1, 32'h1234_5678);
  endtask

  // Basic insert and erase at the head, middle and tail of the list.
  task automatic test_insert_erase();
    send_item(ilie_pkg::OP_APPEND, 5'd0, 32'h0000_0000);
    send_item(ilie_pkg::OP_APPEND, 5'd31, 32'hFFFF_FFFF);
    send_item(ilie_pkg::OP_INSERT, 5'd0, 32'hA5A5_A5A5);
    send_item(ilie_pkg::OP_INSERT, 5'd3, 32'h5A5A_5A5A);
    send_item(ilie_pkg::OP_INSERT, 5'd1, 32'h8000_0001);
    send_item(ilie_pkg::OP_INSERT, 5'd31, 32'hDEAD_BEEF);
    send_item(ilie_pkg::OP_READ, 5'd4, 32'h0);
    send_item(ilie_pkg::OP_READ, 5'd5, 32'h0);
    send_item(ilie_pkg::OP_FRONT, 5'd0, 32'h0);
    send_item(ilie_pkg::OP_BACK, 5'd0, 32'h0);
    send_item(ilie_pkg::OP_ERASE, 5'd0, 32'h0);
    send_item(ilie_pkg::OP_ERASE, 5'd3, 32'h0);
    send_item(ilie_pkg::OP_ERASE, 5'd16, 32'h0);
    send_item(ilie_pkg::OP_DROP, 5'd0, 32'h0);
    send_item(ilie_pkg::OP_CLEAR, 5'd0, 32'h0);
    send_item(ilie_pkg::OP_BACK, 5'd0, 32'h0);
    send_item(ilie_pkg::OP_READ, 5'd0, 32'h0);
  endtask

  // Fills the list and checks the full cases, including the range-before-full order.
  task automatic test_full_list();
    send_item(ilie_pkg::OP_CLEAR, 5'd0, 32'h0);
    for (int i = 0; i < LIST_DEPTH; i++) begin
      send_item(ilie_pkg::OP_INSERT, ilie_pkg::POS_W'($urandom_range(0, i)), $urandom);
    end
    send_item(ilie_pkg::OP_APPEND, 5'd0, 32'hFFFF_FFFF);
    send_item(ilie_pkg::OP_INSERT, 5'd16, 32'h1);
    send_item(ilie_pkg::OP_INSERT, 5'd17, 32'h2);
    send_item(ilie_pkg::OP_INSERT, 5'd0, 32'h3);
    send_item(ilie_pkg::OP_READ, 5'd15, 32'h0);
    send_item(ilie_pkg::OP_READ, 5'd16, 32'h0);
    send_item(ilie_pkg::OP_BACK, 5'd0, 32'h0);
    send_item(ilie_pkg::OP_ERASE, 5'd15, 32'h0);
    send_item(ilie_pkg::OP_INSERT, 5'd15, 32'hCAFE_F00D);
    send_item(ilie_pkg::OP_ERASE, 5'd7, 32'h0);
    send_item(ilie_pkg::OP_APPEND, 5'd0, 32'h0);
  endtask

  // Random traffic; the grow share drifts so the list swings between empty and full.
  task automatic test_random_traffic(input int n_items, input int idle_pct);
    logic [ilie_pkg::OP_W-1:0]   op;
    logic [ilie_pkg::POS_W-1:0]  pos;
    logic [ilie_pkg::WORD_W-1:0] word;
    int                          grow_pct;
    int                          left_in_mode;
    int                          roll;
    sender_idle_pct = idle_pct;
    left_in_mode    = 0;
    grow_pct        = 45;
    for (int n = 0; n < n_items; n++) begin
      if (left_in_mode == 0) begin
        roll         = $urandom_range(2);
        grow_pct     = (roll == 0) ? 25 : (roll == 1) ? 45 : 70;
        left_in_mode = $urandom_range(30, 60);
      end
      left_in_mode--;
      roll = $urandom_range(9);
      word = (roll == 0) ? '0 : (roll == 1) ? '1 : ilie_pkg::WORD_W'($urandom);
      pos  = ilie_pkg::POS_W'($urandom_range(0, 31));
      roll = $urandom_range(99);
      if (roll < 2) begin
        op = ilie_pkg::OP_CLEAR;
      end else if (roll < 6) begin
        // Noise: any operation at any position.
        op = ilie_pkg::OP_W'($urandom_range(0, 7));
      end else if ($urandom_range(99) < grow_pct) begin
        op = $urandom_range(1) ? ilie_pkg::OP_APPEND : ilie_pkg::OP_INSERT;
        if (op == ilie_pkg::OP_INSERT && $urandom_range(9) != 0) begin
          pos = ilie_pkg::POS_W'($urandom_range(0, list_len));
        end
      end else begin
        case ($urandom_range(4))
          0: op = ilie_pkg::OP_DROP;
          1: op = ilie_pkg::OP_ERASE;
          2: op = ilie_pkg::OP_READ;
          3: op = ilie_pkg::OP_FRONT;
          default: op = ilie_pkg::OP_BACK;
        endcase
        if (list_len > 0 && $urandom_range(9) != 0) begin
          pos = ilie_pkg::POS_W'($urandom_range(0, list_len - 1));
        end
      end
      send_item(op, pos, word);
    end
  endtask

  // Main sequence: reset, directed tests, random phases, drain and verdict.
  initial begin
    rst             = 1'b1;
    start           = 1'b0;
    req             = '0;
    list_len        = 0;
    accepted_items  = 0;
    checked_results = 0;
    fail_count      = 0;
    range_results   = 0;
    full_results    = 0;
    full_reached    = 0;
    sender_idle_pct = 0;
    for (int i = 0; i < LIST_DEPTH; i++) list_words[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_list();
    test_insert_erase();
    test_full_list();
    test_random_traffic(RANDOM_ITEMS, 0);
    test_random_traffic(RANDOM_ITEMS, 70);
    test_random_traffic(RANDOM_ITEMS, 0);
    test_random_traffic(RANDOM_ITEMS, 13);

    start <= 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Run covered %0d items and %0d checked results.",
             accepted_items, checked_results);
    $display("Out-of-range results: %0d, list-full results: %0d, items leaving it full: %0d.",
             range_results, full_results, full_reached);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
